// ===== hdl/trf_pkg.sv =====
`timescale 1ns / 1ps

package trf_pkg;

  // Receive parser phases.
  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_FUNC,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  // Work handed from the parser to the response engine.
  typedef enum logic [1:0] {
    CMD_ACK,
    CMD_GAINS,
    CMD_LOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  func;
    logic [7:0]  csum;
  } cmd_t;

  // Response engine states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } back_state_t;

  localparam logic [7:0] SYNC1      = 8'hAA;
  localparam logic [7:0] SYNC2      = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT = 8'hF1;
  localparam logic [7:0] ACK_ID     = 8'hEF;
  localparam logic [7:0] ACK_LEN    = 8'h02;
  localparam logic [7:0] GAIN_ID    = 8'h10;
  localparam logic [7:0] FN_READ    = 8'h01;
  localparam logic [7:0] FN_WRITE   = 8'h10;
  localparam logic [7:0] FN_ACK_LO  = 8'h13;
  localparam logic [7:0] FN_ACK_HI  = 8'h15;

  // Acknowledge frame: AA AA EF 02 function checksum sum.
  localparam int ACK_BYTES = 7;

  // Gains are sent scaled by this factor.
  localparam logic [15:0] GAIN_SCALE = 16'd1000;

  // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x up to 32768.
  localparam logic [15:0] RECIP       = 16'd33555;
  localparam int          RECIP_SHIFT = 25;

endpackage

// ===== hdl/trf_queue.sv =====
`timescale 1ns / 1ps

module trf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output trf_pkg::cmd_t pop_cmd,
  output logic          empty
);

  trf_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command popped from an empty queue");
`endif

endmodule

// ===== hdl/trf_front.sv =====
`timescale 1ns / 1ps

module trf_front #(
  parameter int LENGTH_LIMIT = 50,
  parameter int GAIN_WORDS   = 9,
  localparam int WAW = (GAIN_WORDS > 1) ? $clog2(GAIN_WORDS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     rx_byte,
  output logic           q_push,
  output trf_pkg::cmd_t  q_cmd,
  input  logic           q_full,
  input  logic           load_done,
  input  logic [WAW-1:0] rd_addr,
  output logic [15:0]    rd_word
);

  localparam int PAYLOAD_BYTES = 2 * GAIN_WORDS;

  trf_pkg::phase_t phase;
  trf_pkg::phase_t phase_next;
  logic [5:0]      bytes_left;
  logic [5:0]      payload_index;
  logic [7:0]      running_sum;
  logic [7:0]      function_code;
  logic [7:0]      even_bank [GAIN_WORDS];
  logic [7:0]      odd_bank  [GAIN_WORDS];
  logic            load_pend;

  logic            accept;
  logic            sum_ok;
  logic            store_en;
  logic            code_ack;

  // Input is held off while a gain load still reads the payload banks.
  assign in_ready = !q_full && !load_pend;
  assign accept   = in_valid && in_ready;
  assign rd_word  = {even_bank[rd_addr], odd_bank[rd_addr]};

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        trf_pkg::PH_HDR1: begin
          phase_next = (rx_byte == trf_pkg::SYNC1) ? trf_pkg::PH_HDR2 : trf_pkg::PH_HDR1;
        end
        trf_pkg::PH_HDR2: begin
          phase_next = (rx_byte == trf_pkg::SYNC2) ? trf_pkg::PH_FUNC : trf_pkg::PH_HDR1;
        end
        trf_pkg::PH_FUNC: begin
          phase_next = (rx_byte < trf_pkg::FUNC_LIMIT) ? trf_pkg::PH_LEN : trf_pkg::PH_HDR1;
        end
        trf_pkg::PH_LEN: begin
          phase_next = (rx_byte < 8'(LENGTH_LIMIT)) ? trf_pkg::PH_DATA : trf_pkg::PH_HDR1;
        end
        trf_pkg::PH_DATA: begin
          if (bytes_left == 6'd0) begin
            phase_next = trf_pkg::PH_HDR1;
          end else if (bytes_left == 6'd1) begin
            phase_next = trf_pkg::PH_SUM;
          end else begin
            phase_next = trf_pkg::PH_DATA;
          end
        end
        default: begin
          phase_next = trf_pkg::PH_HDR1;
        end
      endcase
    end
  end

  always_comb begin
    sum_ok   = (rx_byte == running_sum);
    code_ack = (function_code >= trf_pkg::FN_ACK_LO) && (function_code <= trf_pkg::FN_ACK_HI);
    store_en = accept && (phase == trf_pkg::PH_DATA) && (bytes_left != 6'd0) &&
               (payload_index < 6'(PAYLOAD_BYTES));
    q_cmd.func = function_code;
    q_cmd.csum = running_sum;
    if (function_code == trf_pkg::FN_READ) begin
      q_cmd.kind = trf_pkg::CMD_GAINS;
    end else if (function_code == trf_pkg::FN_WRITE) begin
      q_cmd.kind = trf_pkg::CMD_LOAD;
    end else begin
      q_cmd.kind = trf_pkg::CMD_ACK;
    end
    q_push = accept && (phase == trf_pkg::PH_SUM) && sum_ok &&
             ((function_code == trf_pkg::FN_READ) || (function_code == trf_pkg::FN_WRITE) ||
              code_ack);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= trf_pkg::PH_HDR1;
      bytes_left    <= 6'd0;
      payload_index <= 6'd0;
      running_sum   <= 8'd0;
      function_code <= 8'd0;
      load_pend     <= 1'b0;
      for (int i = 0; i < GAIN_WORDS; i++) begin
        even_bank[i] <= 8'd0;
        odd_bank[i]  <= 8'd0;
      end
    end else begin
      phase <= phase_next;
      if (q_push && (q_cmd.kind == trf_pkg::CMD_LOAD)) begin
        load_pend <= 1'b1;
      end else if (load_done) begin
        load_pend <= 1'b0;
      end
      if (accept) begin
        // A mismatch lands in the first header phase, which reloads the sum.
        if (phase == trf_pkg::PH_HDR1) begin
          running_sum <= trf_pkg::SYNC1;
        end else begin
          running_sum <= running_sum + rx_byte;
        end
        if (phase == trf_pkg::PH_FUNC) begin
          function_code <= rx_byte;
        end
        if (phase == trf_pkg::PH_LEN) begin
          bytes_left    <= rx_byte[5:0];
          payload_index <= 6'd0;
        end
        if ((phase == trf_pkg::PH_DATA) && (bytes_left != 6'd0)) begin
          bytes_left    <= bytes_left - 6'd1;
          payload_index <= payload_index + 6'd1;
        end
      end
      if (store_en) begin
        if (payload_index[0]) begin
          odd_bank[payload_index[WAW:1]] <= rx_byte;
        end else begin
          even_bank[payload_index[WAW:1]] <= rx_byte;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_during_load: assert property (@(posedge clk) disable iff (rst)
      load_pend |-> !in_ready)
    else $error("input taken while a gain load is pending");
`endif

endmodule

// ===== hdl/trf_back.sv =====
`timescale 1ns / 1ps

module trf_back #(
  parameter int GAIN_WORDS = 9,
  localparam int WAW = (GAIN_WORDS > 1) ? $clog2(GAIN_WORDS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  trf_pkg::cmd_t  q_cmd,
  output logic           load_done,
  output logic [WAW-1:0] rd_addr,
  input  logic [15:0]    rd_word,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     tx_byte,
  output logic           frame_last
);

  localparam int GAIN_BYTES = 5 + 2 * GAIN_WORDS;

  trf_pkg::back_state_t state;
  trf_pkg::back_state_t state_next;
  trf_pkg::cmd_t        cur;
  logic [WAW-1:0]       widx;
  logic [5:0]           bidx;
  logic [7:0]           tx_sum;
  logic [6:0]           gain_store [GAIN_WORDS];

  logic        emit;
  logic        is_last;
  logic [5:0]  last_idx;
  logic [5:0]  pay_k;
  logic [15:0] gprod;
  logic [7:0]  byte_sel;
  logic        neg;
  logic [15:0] mag;
  logic [31:0] prod;
  logic [6:0]  quo;
  logic [6:0]  gain_new;

  assign rd_addr = widx;

  // Truncating divide by the gain scale: magnitude, reciprocal multiply, sign back.
  always_comb begin
    neg      = rd_word[15];
    mag      = neg ? (16'd0 - rd_word) : rd_word;
    prod     = 32'(mag * trf_pkg::RECIP);
    quo      = prod[trf_pkg::RECIP_SHIFT +: 7];
    gain_new = neg ? (7'd0 - quo) : quo;
  end

  always_comb begin
    last_idx = (cur.kind == trf_pkg::CMD_GAINS) ? 6'(GAIN_BYTES - 1) : 6'(trf_pkg::ACK_BYTES - 1);
    is_last  = (bidx == last_idx);
    pay_k    = bidx - 6'd4;
    gprod    = 16'({{9{gain_store[pay_k[WAW:1]][6]}}, gain_store[pay_k[WAW:1]]} *
                   trf_pkg::GAIN_SCALE);
    if (is_last) begin
      byte_sel = tx_sum;
    end else if (bidx < 6'd2) begin
      byte_sel = trf_pkg::SYNC1;
    end else if (cur.kind == trf_pkg::CMD_GAINS) begin
      if (bidx == 6'd2) begin
        byte_sel = trf_pkg::GAIN_ID;
      end else if (bidx == 6'd3) begin
        byte_sel = 8'(2 * GAIN_WORDS);
      end else begin
        byte_sel = pay_k[0] ? gprod[7:0] : gprod[15:8];
      end
    end else begin
      if (bidx == 6'd2) begin
        byte_sel = trf_pkg::ACK_ID;
      end else if (bidx == 6'd3) begin
        byte_sel = trf_pkg::ACK_LEN;
      end else if (bidx == 6'd4) begin
        byte_sel = cur.func;
      end else begin
        byte_sel = cur.csum;
      end
    end
  end

  always_comb begin
    q_pop     = (state == trf_pkg::ST_IDLE) && !q_empty;
    load_done = (state == trf_pkg::ST_LOAD) && (widx == WAW'(GAIN_WORDS - 1));
    emit      = (state == trf_pkg::ST_EMIT) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      trf_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_next = (q_cmd.kind == trf_pkg::CMD_LOAD) ? trf_pkg::ST_LOAD : trf_pkg::ST_EMIT;
        end
      end
      trf_pkg::ST_LOAD: begin
        if (load_done) begin
          state_next = trf_pkg::ST_EMIT;
        end
      end
      trf_pkg::ST_EMIT: begin
        if (emit && is_last) begin
          state_next = trf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = trf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trf_pkg::ST_IDLE;
      out_valid <= 1'b0;
      widx      <= '0;
      bidx      <= 6'd0;
      tx_sum    <= 8'd0;
      for (int i = 0; i < GAIN_WORDS; i++) begin
        gain_store[i] <= 7'd0;
      end
    end else begin
      state <= state_next;
      if (q_pop) begin
        cur    <= q_cmd;
        widx   <= '0;
        bidx   <= 6'd0;
        tx_sum <= 8'd0;
      end
      if (state == trf_pkg::ST_LOAD) begin
        gain_store[widx] <= gain_new;
        widx             <= widx + 1'b1;
      end
      if (emit) begin
        tx_byte    <= byte_sel;
        frame_last <= is_last;
        out_valid  <= 1'b1;
        bidx       <= bidx + 6'd1;
        tx_sum     <= tx_sum + byte_sel;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ack_after_load: assert property (@(posedge clk) disable iff (rst)
      load_done |=> (state == trf_pkg::ST_EMIT) && (bidx == 6'd0))
    else $error("acknowledge does not start right after the gain load");
`endif

endmodule

// ===== hdl/telemetry_frame_receiver_ack.sv =====
`timescale 1ns / 1ps

// Telemetry frame receiver with acknowledge and gain readback.
// The input channel (in_valid, in_ready, rx_byte) takes one received word per
// handshake. Frames are AA AF, function, length, payload and an 8-bit sum.
// The output channel (out_valid, out_ready, tx_byte, frame_last) returns the
// response frame one word per handshake, with frame_last on its final word.
// A read request (function 0x01) answers with the gain frame of 5 + 2 *
// GAIN_WORDS words; a gain write (0x10) and codes 0x13 to 0x15 answer with a
// 7-word acknowledge. Other frames give no response.
// A response starts once its checksum word is taken and its command has
// passed through the queue, then streams one word per cycle while out_ready
// is high. A gain write first does one divide by 1000 per cycle, one per
// gain word, before its acknowledge. The parser queues up to two responses,
// so it keeps taking words while a frame goes out; it holds in_ready low
// when that queue is full and while a gain write is being applied.
// A stalled receiver holds the current word in the output register.
// Reset clears the parser to wait for a new header, empties the queue, and
// zeroes the stored payload and gains.
module telemetry_frame_receiver_ack #(
  parameter int LENGTH_LIMIT = 50,
  parameter int GAIN_WORDS   = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       frame_last
);

  localparam int WAW = (GAIN_WORDS > 1) ? $clog2(GAIN_WORDS) : 1;

  // Commands from the parser to the response engine.
  trf_pkg::cmd_t  push_cmd;
  trf_pkg::cmd_t  pop_cmd;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // The response engine reads payload words during a gain write.
  logic           load_done;
  logic [WAW-1:0] rd_addr;
  logic [15:0]    rd_word;

  trf_front #(
    .LENGTH_LIMIT(LENGTH_LIMIT),
    .GAIN_WORDS  (GAIN_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .q_full   (q_full),
    .load_done(load_done),
    .rd_addr  (rd_addr),
    .rd_word  (rd_word)
  );

  trf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (pop_cmd),
    .empty   (q_empty)
  );

  trf_back #(
    .GAIN_WORDS(GAIN_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .load_done (load_done),
    .rd_addr   (rd_addr),
    .rd_word   (rd_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .frame_last(frame_last)
  );

endmodule
